>>> sv/clock_page_replacement_defines.svh
// ----------------------------------------------------------------------------
// Clock page replacement assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication, held off during reset
`define CPR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("clock_page_replacement check failed");

// next-cycle implication, held off during reset
`define CPR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("clock_page_replacement check failed");

`endif

>>> sv/cpr_pkg.sv
// ----------------------------------------------------------------------------
// cpr_pkg
// Sizes, register map and result word layout for clock page replacement.
// ----------------------------------------------------------------------------
package cpr_pkg;

   localparam int FRAMES    = 16;
   localparam int PAGE_BITS = 20;

   localparam int PAGE_W    = 20;
   localparam int FRAME_W   = 4;
   localparam int COUNT_W   = 32;
   localparam int CFG_W     = 5;

   localparam int IDX_W     = $clog2(FRAMES);
   localparam int FILL_W    = $clog2(FRAMES + 1);
   localparam int STORE_W   = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
   localparam int CMP_W     = (FILL_W > CFG_W) ? FILL_W : CFG_W;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USED_W = 2 + PAGE_W + FRAME_W + COUNT_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_FRAMES = 3'd0;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'((FRAMES < 16) ? FRAMES : 16);

   typedef struct packed {
      logic [COUNT_W-1:0] miss_count;
      logic [FRAME_W-1:0] frame_index;
      logic [PAGE_W-1:0]  victim_page;
      logic               evicted;
      logic               hit;
   } rsp_type;

   function automatic logic [FILL_W-1:0] active_frames(input logic [CFG_W-1:0] cfg);
      logic [CMP_W-1:0] ext;
      ext = CMP_W'(cfg);
      if (cfg == '0) begin
         return FILL_W'(1);
      end else if (ext > CMP_W'(FRAMES)) begin
         return FILL_W'(FRAMES);
      end else begin
         return FILL_W'(cfg);
      end
   endfunction

endpackage

>>> sv/clock_page_replacement.sv
// ----------------------------------------------------------------------------
// clock_page_replacement
// Second-chance page replacement over a frame table held in a synchronous
// memory; reference bits, hand and fill count live in flops.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  req     | in        | req_tvalid/req_tready  | page
//  rsp     | out       | rsp_tvalid/rsp_tready  | hit, evicted, victim, frame, count
//  csr     | in/out    | APB, pready tied high  | frames_in_use at 0x0
//
//  A lookup reads one frame entry per cycle through the memory read port
//  and compares it with the page once registered; a fault fills the next
//  free frame, or sweeps the hand past set reference bits, clearing them,
//  and reads the victim from the first clear one. One word is in flight;
//  the next is taken while the previous result waits in the output register.
//  Reset clears control state and reference bits; frame page entries are
//  read only below the fill count.
// ----------------------------------------------------------------------------
module clock_page_replacement
   import cpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // page[19:0], zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // hit, evicted, victim_page[19:0],
                                             // frame_index[3:0], miss_count[31:0]
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_SWEEP = 3'd2;
   localparam logic [2:0] ST_VCAP  = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [STORE_W-1:0] page_ff, page_in;
   logic [FILL_W-1:0]  scan_ptr_ff, scan_ptr_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]   hand_ff, hand_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [FILL_W-1:0]  filled_ff, filled_in;
   logic [FRAMES-1:0]  ref_ff, ref_in;
   logic [COUNT_W-1:0] fault_ff, fault_in;
   logic [CFG_W-1:0]   frames_cfg_ff, frames_cfg_in;
   rsp_type            res_ff, res_in;
   logic               rsp_vld_ff, rsp_vld_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [STORE_W-1:0] page_mem [FRAMES];
   logic [STORE_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;

   logic [FILL_W-1:0]  n_active;
   logic [IDX_W-1:0]   hand_next;
   logic [COUNT_W-1:0] fault_inc;
   logic               csr_wr;

   assign n_active  = active_frames(frames_cfg_ff);
   assign hand_next = ((FILL_W'(hand_ff) + FILL_W'(1)) == n_active) ? '0
                      : IDX_W'(hand_ff + IDX_W'(1));
   assign fault_inc = (fault_ff == '1) ? fault_ff : fault_ff + COUNT_W'(1);
   assign csr_wr    = csr_psel & csr_penable & csr_pwrite & csr_pready
                      & (csr_paddr == CSR_ADDR_FRAMES);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_FRAMES) ? CSR_DATA_W'(frames_cfg_ff) : '0;

   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      scan_ptr_in   = scan_ptr_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hand_in       = hand_ff;
      slot_in       = slot_ff;
      filled_in     = filled_ff;
      ref_in        = ref_ff;
      fault_in      = fault_ff;
      frames_cfg_in = frames_cfg_ff;
      res_in        = res_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = scan_ptr_ff[IDX_W-1:0];
      mem_we        = 1'b0;
      mem_waddr     = slot_ff;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               page_in     = STORE_W'(req_tdata[PAGE_W-1:0]);
               scan_ptr_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_vld_ff && (rd_data_ff == page_ff)) begin
               ref_in[cmp_idx_ff] = 1'b1;
               res_in.hit         = 1'b1;
               res_in.evicted     = 1'b0;
               res_in.victim_page = '0;
               res_in.frame_index = FRAME_W'(cmp_idx_ff);
               res_in.miss_count  = fault_ff;
               state_in           = ST_FIN;
            end else if (!cmp_vld_ff && (scan_ptr_ff == filled_ff)) begin
               fault_in           = fault_inc;
               res_in.hit         = 1'b0;
               res_in.miss_count  = fault_inc;
               if (filled_ff < n_active) begin
                  mem_we             = 1'b1;
                  mem_waddr          = filled_ff[IDX_W-1:0];
                  ref_in[filled_ff[IDX_W-1:0]] = 1'b1;
                  filled_in          = filled_ff + FILL_W'(1);
                  res_in.evicted     = 1'b0;
                  res_in.victim_page = '0;
                  res_in.frame_index = FRAME_W'(filled_ff[IDX_W-1:0]);
                  state_in           = ST_FIN;
               end else begin
                  state_in = ST_SWEEP;
               end
            end else begin
               cmp_vld_in = (scan_ptr_ff < filled_ff);
               cmp_idx_in = scan_ptr_ff[IDX_W-1:0];
               if (scan_ptr_ff < filled_ff) begin
                  scan_ptr_in = scan_ptr_ff + FILL_W'(1);
               end
            end
         end
         ST_SWEEP: begin
            rd_addr = hand_ff;
            hand_in = hand_next;
            if (ref_ff[hand_ff]) begin
               ref_in[hand_ff] = 1'b0;
            end else begin
               slot_in  = hand_ff;
               state_in = ST_VCAP;
            end
         end
         ST_VCAP: begin
            mem_we             = 1'b1;
            mem_waddr          = slot_ff;
            ref_in[slot_ff]    = 1'b1;
            res_in.evicted     = 1'b1;
            res_in.victim_page = PAGE_W'(rd_data_ff);
            res_in.frame_index = FRAME_W'(slot_ff);
            state_in           = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = res_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr) begin
         frames_cfg_in = csr_pwdata[CFG_W-1:0];
         filled_in     = '0;
         hand_in       = '0;
         ref_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmp_vld_ff    <= 1'b0;
         hand_ff       <= '0;
         filled_ff     <= '0;
         ref_ff        <= '0;
         fault_ff      <= '0;
         frames_cfg_ff <= CFG_RESET;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmp_vld_ff    <= cmp_vld_in;
         hand_ff       <= hand_in;
         filled_ff     <= filled_in;
         ref_ff        <= ref_in;
         fault_ff      <= fault_in;
         frames_cfg_ff <= frames_cfg_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      scan_ptr_ff <= scan_ptr_in;
      cmp_idx_ff  <= cmp_idx_in;
      slot_ff     <= slot_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[mem_waddr] <= page_ff;
      end
      rd_data_ff <= page_mem[rd_addr];
   end

endmodule

>>> sv/cpr_checker.sv
// ----------------------------------------------------------------------------
// cpr_checker
// Port-level checks on the result channel of clock page replacement.
// ----------------------------------------------------------------------------
`include "clock_page_replacement_defines.svh"

module cpr_checker
   import cpr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_type rsp_word;
   logic    rsp_stall;
   logic    hit_clean;

   assign rsp_word  = rsp_type'(rsp_tdata[RSP_USED_W-1:0]);
   assign rsp_stall = rsp_tvalid & ~rsp_tready;
   assign hit_clean = !rsp_word.evicted && (rsp_word.victim_page == '0);

   `CPR_ASSERT_NOW(a_hit_no_victim, rsp_tvalid && rsp_word.hit, hit_clean)
   `CPR_ASSERT_NOW(a_fill_no_victim, rsp_tvalid && !rsp_word.evicted, rsp_word.victim_page == '0)
   `CPR_ASSERT_NEXT(a_stall_hold_valid, rsp_stall, rsp_tvalid)
   `CPR_ASSERT_NEXT(a_stall_hold_data, rsp_stall, $stable(rsp_tdata))

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (.*);
